// ===== rtl/e2r_pkg.sv =====
// ============================================================================
// e2r_pkg: shared types, constants and helpers for the Euler-to-rotation block
// Holds the CORDIC arctangent table, fixed widths and the convention codes.
// ============================================================================
package e2r_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF  = 16;
  localparam int IN_W           = 16;
  localparam int OUT_W          = 16;
  localparam int OUT_FRAC       = 14;
  localparam int WORK_FRAC      = 30;
  localparam int ATAN_COUNT     = 28;
  // CORDIC datapath: 30 fraction bits, |x|,|y| < 2^31 with headroom
  localparam int CW             = 34;
  localparam int ZW             = 34;

  typedef enum logic [1:0] {
    CONV_ZXY = 2'd0,
    CONV_ZYX = 2'd1,
    CONV_YXZ = 2'd2,
    CONV_RSV = 2'd3
  } conv_t;

  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] v;
    v = '0;
    case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458905;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      24: v = 34'sd41;
      25: v = 34'sd20;
      26: v = 34'sd10;
      27: v = 34'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/e2r_sincos.sv =====
// ============================================================================
// e2r_sincos: pipelined CORDIC sine/cosine lane
// One CORDIC rotation per stage; quadrant fold up front, round/clamp at end.
// ============================================================================
module e2r_sincos import e2r_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int COEF_BITS  = COEF_BITS_DEF,
  parameter int ITERS      = (COEF_BITS + 2 > ATAN_COUNT) ? ATAN_COUNT : COEF_BITS + 2
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [IN_W-1:0]        angle,
  output logic signed [COEF_BITS-1:0] sin_o,
  output logic signed [COEF_BITS-1:0] cos_o
);

  localparam int FRAC = COEF_BITS - 2;
  localparam int SH   = WORK_FRAC - FRAC;

  logic [ANGLE_BITS-1:0] a_res;
  logic [31:0]           phase;
  logic signed [ZW-1:0]  z0;
  logic                  flip0;

  // angle resolution and quadrant fold
  always_comb begin
    if (ANGLE_BITS >= IN_W) a_res = ANGLE_BITS'(angle) << (ANGLE_BITS - IN_W);
    else                    a_res = ANGLE_BITS'(angle >> (IN_W - ANGLE_BITS));
    phase = {a_res, {(32-ANGLE_BITS){1'b0}}};
    z0    = ZW'($signed(phase));
    flip0 = 1'b0;
    if (z0 > 34'sd1073741824) begin
      z0 = z0 - 34'sd2147483648; flip0 = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      z0 = z0 + 34'sd2147483648; flip0 = 1'b1;
    end
  end

  logic signed [CW-1:0] x_r [0:ITERS];
  logic signed [CW-1:0] y_r [0:ITERS];
  logic signed [ZW-1:0] z_r [0:ITERS];
  logic                 f_r [0:ITERS];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= 34'sd652032874;
      y_r[0] <= '0;
      z_r[0] <= z0;
      f_r[0] <= flip0;
    end
  end

  // one rotation per stage (>>> is a floor shift)
  for (genvar i = 0; i < ITERS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_lut(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_lut(i);
        end
      end
    end
  end

  // round half up, sign fold, clamp
  logic signed [CW-1:0] xr, yr, xo, yo;
  localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC;
  localparam logic signed [CW-1:0] HALF = CW'(1) <<< (SH - 1);
  always_comb begin
    xr = (x_r[ITERS] + HALF) >>> SH;
    yr = (y_r[ITERS] + HALF) >>> SH;
    if (f_r[ITERS]) begin xr = -xr; yr = -yr; end
    xo = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
    yo = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= xo[COEF_BITS-1:0];
      sin_o <= yo[COEF_BITS-1:0];
    end
  end

endmodule

// ===== rtl/e2r_matmul.sv =====
// ============================================================================
// e2r_matmul: merges three lane sine/cosine pairs into the rotation matrix
// Two registered 3x3 products, then output scaling and clamp.
// ============================================================================
module e2r_matmul import e2r_pkg::*; #(
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  conv_t                       conv,
  input  logic signed [COEF_BITS-1:0] s_i [3],
  input  logic signed [COEF_BITS-1:0] c_i [3],
  output logic [OUT_W-1:0]            m_o [9]
);

  localparam int FRAC = COEF_BITS - 2;
  localparam int PW   = 2 * COEF_BITS + 4;
  localparam logic signed [COEF_BITS-1:0] ONE = COEF_BITS'(1) <<< FRAC;

  typedef logic signed [COEF_BITS-1:0] mat_t [9];

  function automatic mat_t rotm(input int axis, input logic signed [COEF_BITS-1:0] s,
                                input logic signed [COEF_BITS-1:0] c);
    mat_t m;
    for (int k = 0; k < 9; k++) m[k] = '0;
    case (axis)
      0: begin m[0] = ONE; m[4] = c; m[5] = -s; m[7] = s; m[8] = c; end
      1: begin m[0] = c; m[2] = s; m[4] = ONE; m[6] = -s; m[8] = c; end
      default: begin m[0] = c; m[1] = -s; m[3] = s; m[4] = c; m[8] = ONE; end
    endcase
    return m;
  endfunction

  function automatic logic signed [COEF_BITS-1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + (PW'(1) <<< (FRAC - 1))) >>> FRAC;
    return t[COEF_BITS-1:0];
  endfunction

  mat_t a, b, c;
  always_comb begin
    case (conv)
      CONV_ZYX: begin
        a = rotm(2, s_i[2], c_i[2]); b = rotm(1, s_i[1], c_i[1]);
        c = rotm(0, s_i[0], c_i[0]);
      end
      CONV_YXZ: begin
        a = rotm(1, s_i[2], c_i[2]); b = rotm(0, s_i[1], c_i[1]);
        c = rotm(2, s_i[0], c_i[0]);
      end
      default: begin
        a = rotm(2, s_i[2], c_i[2]); b = rotm(0, s_i[0], c_i[0]);
        c = rotm(1, s_i[1], c_i[1]);
      end
    endcase
  end

  // stage 1: t = a*b, c delayed
  mat_t t_r, c_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          t_r[i*3+j] <= rnd(PW'(a[i*3]) * PW'(b[j]) + PW'(a[i*3+1]) * PW'(b[3+j])
                          + PW'(a[i*3+2]) * PW'(b[6+j]));
      c_r <= c;
    end
  end

  // stage 2: m = t*c, scale to Q2.14, clamp
  logic signed [PW-1:0] v [9];
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        v[i*3+j] = PW'(rnd(PW'(t_r[i*3]) * PW'(c_r[j]) + PW'(t_r[i*3+1]) * PW'(c_r[3+j])
                   + PW'(t_r[i*3+2]) * PW'(c_r[6+j])));
        if (FRAC >= OUT_FRAC) begin
          if (FRAC > OUT_FRAC)
            v[i*3+j] = (v[i*3+j] + (PW'(1) <<< (FRAC - OUT_FRAC - 1))) >>> (FRAC - OUT_FRAC);
        end else begin
          v[i*3+j] = v[i*3+j] <<< (OUT_FRAC - FRAC);
        end
        if (v[i*3+j] > PW'(16384)) v[i*3+j] = PW'(16384);
        if (v[i*3+j] < -PW'(16384)) v[i*3+j] = -PW'(16384);
      end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) m_o[k] <= v[k][OUT_W-1:0];
    end
  end

endmodule

// ===== rtl/euler_to_rotation_matrix.sv =====
// ============================================================================
// euler_to_rotation_matrix: three binary Euler angles to a Q2.14 DCM
// Three CORDIC lanes feed a two-stage matrix product merge.
// ============================================================================
// channel | dir | payload
// in_     | in  | tdata[47:0]  = angle_0, angle_1, angle_2
// out_    | out | tdata[143:0] = m00..m22 row major
// cfg_    | in  | data[1:0]    = convention
// One item per cycle while the output is not stalled; ITERS+4 register stages
// in all, of which the CORDIC stages dominate.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears the valid pipe and the convention register.
module euler_to_rotation_matrix import e2r_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int COEF_BITS  = COEF_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // angle_0, angle_1, angle_2
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // m00,m01,m02,m10,m11,m12,m20,m21,m22
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data    // convention
);

  localparam int ITERS = (COEF_BITS + 2 > ATAN_COUNT) ? ATAN_COUNT : COEF_BITS + 2;
  localparam int LAT   = ITERS + 4;

  logic  en;
  logic  [LAT-1:0] vld_r;
  conv_t conv_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign out_tvalid = vld_r[LAT-1];

  // valid shift and convention register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      conv_r <= CONV_ZXY;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
      if (cfg_valid) conv_r <= conv_t'(cfg_data);
    end
  end

  logic signed [COEF_BITS-1:0] s_w [3];
  logic signed [COEF_BITS-1:0] c_w [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    e2r_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS), .ITERS(ITERS)) u_sc (
      .clk(clk), .en(en), .angle(in_tdata[l*IN_W +: IN_W]),
      .sin_o(s_w[l]), .cos_o(c_w[l])
    );
  end

  logic [OUT_W-1:0] m_w [9];
  e2r_matmul #(.COEF_BITS(COEF_BITS)) u_mm (
    .clk(clk), .en(en), .conv(conv_r), .s_i(s_w), .c_i(c_w), .m_o(m_w)
  );

  for (genvar k = 0; k < 9; k++) begin : g_out
    assign out_tdata[k*OUT_W +: OUT_W] = m_w[k];
  end

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  // input accepted whenever output side not blocked
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

// ===== dv/euler_to_rotation_matrix_tb.sv =====
// ============================================================================
// euler_to_rotation_matrix_tb: self-checking bench for the Euler-to-DCM block
// Drives angle triples under every axis convention, predicts each Q2.14
// matrix with a bit-exact CORDIC and product model, and compares every field
// of every result with random sender gaps and receiver stalls.
// ============================================================================
module euler_to_rotation_matrix_tb;
  import e2r_pkg::*;

  localparam int FRAC   = 14;   // COEF_BITS-2
  localparam int ITERS  = 18;   // COEF_BITS+2
  localparam int LAT    = ITERS + 5;

  typedef struct packed {
    logic signed [15:0] a2;
    logic signed [15:0] a1;
    logic signed [15:0] a0;
  } angles_t;

  typedef logic signed [15:0] mat_t [9];
  typedef longint m3_t [3][3];

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_data;

  conv_t        cur_conv;
  logic [143:0] matrix_q[$];
  int           mismatch_cnt = 0;
  bit           failed = 1'b0;
  int           stall_mode = 0;

  euler_to_rotation_matrix u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshr(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint atan_val(int i);
    longint t [28] = '{536870912, 316933406, 167458905, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5};
    return t[i];
  endfunction

  task automatic cordic_sincos(input logic [15:0] ang, output longint sn,
                               output longint cs);
    longint z, x, y, dx, dy, one;
    bit flip;
    one = longint'(1) <<< FRAC;
    z = longint'($signed({ang, 16'h0000}));
    flip = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; flip = 1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_val(i);
      end else begin
        x += dx; y -= dy; z += atan_val(i);
      end
    end
    x = rshr(x, 30 - FRAC);
    y = rshr(y, 30 - FRAC);
    if (flip) begin
      x = -x; y = -y;
    end
    if (x > one) x = one;
    if (x < -one) x = -one;
    if (y > one) y = one;
    if (y < -one) y = -one;
    sn = y;
    cs = x;
  endtask

  // axis 0 = x, 1 = y, 2 = z
  task automatic axis_rot(input int axis, input logic [15:0] ang, output m3_t m);
    longint s, c, one;
    one = longint'(1) <<< FRAC;
    cordic_sincos(ang, s, c);
    foreach (m[i, j]) m[i][j] = 0;
    case (axis)
      0: begin
        m[0][0] = one; m[1][1] = c; m[1][2] = -s; m[2][1] = s; m[2][2] = c;
      end
      1: begin
        m[0][0] = c; m[0][2] = s; m[1][1] = one; m[2][0] = -s; m[2][2] = c;
      end
      default: begin
        m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c; m[2][2] = one;
      end
    endcase
  endtask

  task automatic mat_prod(input m3_t a, input m3_t b, output m3_t r);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
        r[i][j] = rshr(acc, FRAC);
      end
  endtask

  task automatic predict_matrix(input angles_t a, output logic [143:0] res);
    m3_t r1, r2, r3, t, m;
    longint v;
    case (cur_conv)
      CONV_ZYX: begin
        axis_rot(2, a.a2, r1); axis_rot(1, a.a1, r2); axis_rot(0, a.a0, r3);
      end
      CONV_YXZ: begin
        axis_rot(1, a.a2, r1); axis_rot(0, a.a1, r2); axis_rot(2, a.a0, r3);
      end
      default: begin
        axis_rot(2, a.a2, r1); axis_rot(0, a.a0, r2); axis_rot(1, a.a1, r3);
      end
    endcase
    mat_prod(r1, r2, t);
    mat_prod(t, r3, m);
    for (int i = 0; i < 9; i++) begin
      v = rshr(m[i / 3][i % 3], FRAC - OUT_FRAC);
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      res[i*16 +: 16] = v[15:0];
    end
  endtask

  // ---------------------------------------------------------------- sender
  task automatic send_angles(input angles_t a);
    logic [143:0] exp_m;
    predict_matrix(a, exp_m);
    matrix_q = {matrix_q, exp_m};
    in_tvalid <= 1'b1;
    in_tdata  <= a;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_burst(input angles_t list[$]);
    int burst;
    burst = 0;
    foreach (list[i]) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      send_angles(list[i]);
      burst--;
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_convention(input conv_t c);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_conv = c;
  endtask

  function automatic angles_t rand_angles();
    angles_t a;
    int sel;
    sel = $urandom_range(0, 9);
    a = angles_t'(48'({$urandom(), $urandom()}));
    // bias some angles to quadrant edges where folding kicks in
    if (sel == 0) a.a0 = 16'(16'sh4000 + $urandom_range(0, 4) - 2);
    if (sel == 1) a.a1 = 16'(16'shC000 + $urandom_range(0, 4) - 2);
    if (sel == 2) a.a2 = 16'(16'sh8000 + $urandom_range(0, 2));
    return a;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    logic [143:0] exp_m;
    if (rst_n && out_tvalid && out_tready) begin
      if (matrix_q.size() == 0) begin
        failed = 1;
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected matrix %h", out_tdata);
      end else begin
        exp_m = matrix_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_tdata[i*16 +: 16] !== exp_m[i*16 +: 16]) begin
            failed = 1;
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("m%0d%0d mismatch: expected %0d actual %0d", i / 3, i % 3,
                       $signed(exp_m[i*16 +: 16]), $signed(out_tdata[i*16 +: 16]));
          end
      end
    end
  end

  // receiver stall pattern: phases of always-ready, periodic, random
  always @(posedge clk) begin
    int cyc;
    cyc++;
    if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= (cyc % 5) != 0 && (cyc % 7) != 3;
      default: out_tready <= $urandom_range(0, 3) != 0;
    endcase
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    angles_t l[$];
    logic [15:0] edges[8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000,
                              16'hC000, 16'h0001, 16'hFFFF, 16'h2000};
    for (int i = 0; i < 8; i++)
      l = {l, angles_t'({edges[(i + 2) % 8], edges[(i + 5) % 8], edges[i]})};
    l = {l, angles_t'({16'h5555, 16'hAAAA, 16'h1234})};
    send_burst(l);
  endtask

  task automatic test_conventions();
    conv_t order[4] = '{CONV_ZYX, CONV_YXZ, CONV_RSV, CONV_ZXY};
    foreach (order[i]) begin
      write_convention(order[i]);
      test_directed();
    end
  endtask

  task automatic test_random(input int n);
    angles_t l[$];
    for (int i = 0; i < n; i++) l = {l, rand_angles()};
    send_burst(l);
  endtask

  task automatic test_random_all_conv();
    conv_t order[5] = '{CONV_YXZ, CONV_ZXY, CONV_ZYX, CONV_RSV, CONV_YXZ};
    foreach (order[i]) begin
      write_convention(order[i]);
      test_random(300);
      // sender holds off until the pipe is empty, then resumes
      while (matrix_q.size() != 0) @(posedge clk);
      test_random(50);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = CONV_ZXY;
    cur_conv   = CONV_ZXY;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_conventions();
    test_random_all_conv();
    drain_results();
    if (!failed) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
